@@ design/sjgad_pkg.sv @@
package sjgad_pkg;

   localparam int COLUMN_BITS  = 13;
   localparam int DRAW_BITS    = COLUMN_BITS + 1;
   localparam int GLYPH_BYTES  = 16;
   localparam int GLYPH_SHIFT  = $clog2(GLYPH_BYTES);
   localparam int OFFSET_BITS  = 19;
   localparam int ADDR_BITS    = 3;
   localparam int DATA_BITS    = 32;

   localparam logic [ADDR_BITS-1:0] REG_LANG_MODE = 3'd0;

   localparam logic [7:0] LEAD_LO_A  = 8'h81;
   localparam logic [7:0] LEAD_HI_A  = 8'h9f;
   localparam logic [7:0] LEAD_LO_B  = 8'he0;
   localparam logic [7:0] LEAD_HI_B  = 8'hfc;
   localparam logic [7:0] TRAIL_LO_A = 8'h40;
   localparam logic [7:0] TRAIL_HI_A = 8'h7e;
   localparam logic [7:0] TRAIL_LO_B = 8'h80;
   localparam logic [7:0] TRAIL_HI_B = 8'h9e;
   localparam logic [7:0] TRAIL_LO_C = 8'h9f;
   localparam logic [7:0] TRAIL_HI_C = 8'hfc;
   localparam logic [6:0] ROW_OFS_B  = 7'd62;
   localparam logic [6:0] CELL_OFS_B = 7'd63;
   localparam logic [6:0] CELLS      = 7'd94;
   localparam logic [OFFSET_BITS-1:0] WIDE_BASE = OFFSET_BITS'(256 * GLYPH_BYTES);

   localparam logic FONT_SINGLE = 1'b0;
   localparam logic FONT_WIDE   = 1'b1;

   // accepted byte with its column and decode context
   typedef struct packed {
      logic [7:0]             text_byte;
      logic [COLUMN_BITS-1:0] col;
      logic [7:0]             lead;
      logic                   mode;
   } item_type;

   // decoded command; pair means two halves from base offset
   typedef struct packed {
      logic                   emit;
      logic                   pair;
      logic                   font;
      logic [OFFSET_BITS-1:0] offset;
      logic [COLUMN_BITS-1:0] col;
   } cmd_type;

   function automatic logic is_lead(input logic [7:0] b);
      return (b >= LEAD_LO_A && b <= LEAD_HI_A) || (b >= LEAD_LO_B && b <= LEAD_HI_B);
   endfunction

endpackage

@@ design/shift_jis_glyph_address_decoder_unit.sv @@
// Bytes are registered in s1, decoded, then loaded into the output register.
// One byte per cycle while req_stall is low (a lead byte emits nothing);
// a double-byte trail takes two result beats, holding back the next one.
// A pending register holds the second half while the next byte is decoded.
// Reset (synchronous): mode 0, no lead byte held, column 0, pipeline empty.
module shift_jis_glyph_address_decoder_unit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  logic [7:0]                              req_text_byte,
   input  logic                                    req_string_start,
   input  logic [sjgad_pkg::COLUMN_BITS-1:0]       req_start_column,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic                                    rsp_font_select,
   output logic [sjgad_pkg::OFFSET_BITS-1:0]       rsp_glyph_offset,
   output logic signed [sjgad_pkg::DRAW_BITS-1:0]  rsp_draw_column,
   output logic                                    rsp_last_half,
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [sjgad_pkg::ADDR_BITS-1:0]         paddr,
   input  logic [sjgad_pkg::DATA_BITS-1:0]         pwdata,
   output logic [sjgad_pkg::DATA_BITS-1:0]         prdata,
   output logic                                    pready
);

   logic                                   mode_ff, mode_in;
   logic [7:0]                             held_ff, held_in;
   logic [sjgad_pkg::COLUMN_BITS-1:0]      column_ff, column_in;
   logic                                   s1_valid_ff, s1_valid_in;
   sjgad_pkg::item_type                    s1_ff, s1_in;
   sjgad_pkg::cmd_type                     cmd;
   logic                                   cmd_free;
   logic                                   s1_adv;
   logic                                   accept;
   logic                                   reg_hit;
   logic [sjgad_pkg::COLUMN_BITS-1:0]      x;

   // register file
   assign pready  = 1'b1;
   assign reg_hit = paddr[sjgad_pkg::ADDR_BITS-1] ==
                    sjgad_pkg::REG_LANG_MODE[sjgad_pkg::ADDR_BITS-1];
   assign mode_in = (psel && penable && pwrite && reg_hit) ? pwdata[0] : mode_ff;
   assign prdata  = reg_hit ? {{(sjgad_pkg::DATA_BITS-1){1'b0}}, mode_ff} : '0;

   // front end: column and lead tracking at accept
   assign s1_adv    = s1_valid_ff && (!cmd.emit || cmd_free);
   assign req_stall = s1_valid_ff && !s1_adv;
   assign accept    = req_valid && !req_stall;
   assign x         = req_string_start ? req_start_column : column_ff;

   always_comb begin
      column_in = column_ff;
      held_in   = held_ff;
      if (accept) begin
         column_in = x + sjgad_pkg::COLUMN_BITS'(8);
         if (mode_ff) begin
            if (held_ff != 8'd0) begin
               held_in = 8'd0;
            end else if (sjgad_pkg::is_lead(req_text_byte)) begin
               held_in = req_text_byte;
            end
         end
      end
      s1_valid_in      = accept || (s1_valid_ff && !s1_adv);
      s1_in            = s1_ff;
      if (accept) begin
         s1_in.text_byte = req_text_byte;
         s1_in.col       = x;
         s1_in.lead      = held_ff;
         s1_in.mode      = mode_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= 1'b0;
         held_ff     <= 8'd0;
         column_ff   <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         mode_ff     <= mode_in;
         held_ff     <= held_in;
         column_ff   <= column_in;
         s1_valid_ff <= s1_valid_in;
      end
      s1_ff <= s1_in;
   end

   sjgad_decode u_decode (
      .item (s1_ff),
      .cmd  (cmd)
   );

   sjgad_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (s1_valid_ff && cmd.emit),
      .cmd              (cmd),
      .cmd_free         (cmd_free),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_font_select  (rsp_font_select),
      .rsp_glyph_offset (rsp_glyph_offset),
      .rsp_draw_column  (rsp_draw_column),
      .rsp_last_half    (rsp_last_half)
   );

   a_first_half_wide: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_half |-> rsp_font_select == sjgad_pkg::FONT_WIDE)
      else $error("first half on single-byte font");

   a_second_half_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_half && !rsp_stall |=> rsp_valid && rsp_last_half)
      else $error("second half missing after first half beat");

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && cmd.emit && rsp_valid)
      else $error("input stalled with nothing blocking");

endmodule

@@ design/sjgad_decode.sv @@
module sjgad_decode (
   input  sjgad_pkg::item_type item,
   output sjgad_pkg::cmd_type  cmd
);

   logic [7:0]  lead_rel;
   logic [6:0]  row_k;
   logic [6:0]  row_adj;
   logic [6:0]  cell_t;
   logic [7:0]  trail_rel;
   logic [13:0] idx;
   logic [sjgad_pkg::OFFSET_BITS-1:0] single_ofs;
   logic [sjgad_pkg::OFFSET_BITS-1:0] pair_ofs;

   always_comb begin
      if (item.lead <= sjgad_pkg::LEAD_HI_A) begin
         lead_rel = item.lead - sjgad_pkg::LEAD_LO_A;
         row_k    = {lead_rel[5:0], 1'b0};
      end else begin
         lead_rel = item.lead - sjgad_pkg::LEAD_LO_B;
         row_k    = {lead_rel[5:0], 1'b0} + sjgad_pkg::ROW_OFS_B;
      end

      row_adj   = row_k;
      trail_rel = 8'd0;
      cell_t    = 7'd0;
      if (item.text_byte >= sjgad_pkg::TRAIL_LO_A && item.text_byte <= sjgad_pkg::TRAIL_HI_A) begin
         trail_rel = item.text_byte - sjgad_pkg::TRAIL_LO_A;
         cell_t    = trail_rel[6:0];
      end else if (item.text_byte >= sjgad_pkg::TRAIL_LO_B &&
                   item.text_byte <= sjgad_pkg::TRAIL_HI_B) begin
         trail_rel = item.text_byte - sjgad_pkg::TRAIL_LO_B;
         cell_t    = trail_rel[6:0] + sjgad_pkg::CELL_OFS_B;
      end else if (item.text_byte >= sjgad_pkg::TRAIL_LO_C &&
                   item.text_byte <= sjgad_pkg::TRAIL_HI_C) begin
         trail_rel = item.text_byte - sjgad_pkg::TRAIL_LO_C;
         cell_t    = trail_rel[6:0];
         row_adj   = row_k + 7'd1;
      end

      idx        = 14'(row_adj) * 14'(sjgad_pkg::CELLS) + 14'(cell_t);
      single_ofs = sjgad_pkg::OFFSET_BITS'({item.text_byte, sjgad_pkg::GLYPH_SHIFT'(0)});
      pair_ofs   = sjgad_pkg::WIDE_BASE
                 + sjgad_pkg::OFFSET_BITS'({idx, 1'b0, sjgad_pkg::GLYPH_SHIFT'(0)});

      cmd.col = item.col;
      if (!item.mode) begin
         cmd.emit   = 1'b1;
         cmd.pair   = 1'b0;
         cmd.font   = sjgad_pkg::FONT_SINGLE;
         cmd.offset = single_ofs;
      end else if (item.lead == 8'd0) begin
         cmd.emit   = !sjgad_pkg::is_lead(item.text_byte);
         cmd.pair   = 1'b0;
         cmd.font   = sjgad_pkg::FONT_WIDE;
         cmd.offset = single_ofs;
      end else begin
         cmd.emit   = 1'b1;
         cmd.pair   = 1'b1;
         cmd.font   = sjgad_pkg::FONT_WIDE;
         cmd.offset = pair_ofs;
      end
   end

endmodule

@@ design/sjgad_emit.sv @@
module sjgad_emit (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    cmd_valid,
   input  sjgad_pkg::cmd_type                      cmd,
   output logic                                    cmd_free,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output logic                                    rsp_font_select,
   output logic [sjgad_pkg::OFFSET_BITS-1:0]       rsp_glyph_offset,
   output logic signed [sjgad_pkg::DRAW_BITS-1:0]  rsp_draw_column,
   output logic                                    rsp_last_half
);

   logic                                   out_valid_ff, out_valid_in;
   logic                                   out_font_ff, out_font_in;
   logic [sjgad_pkg::OFFSET_BITS-1:0]      out_ofs_ff, out_ofs_in;
   logic [sjgad_pkg::DRAW_BITS-1:0]        out_col_ff, out_col_in;
   logic                                   out_last_ff, out_last_in;
   logic                                   pend_ff, pend_in;
   logic [sjgad_pkg::OFFSET_BITS-1:0]      pend_ofs_ff, pend_ofs_in;
   logic [sjgad_pkg::DRAW_BITS-1:0]        pend_col_ff, pend_col_in;
   logic                                   load;
   logic                                   beat;
   logic [sjgad_pkg::DRAW_BITS-1:0]        col_ext;

   assign beat     = out_valid_ff && !rsp_stall;
   assign cmd_free = !out_valid_ff || (beat && !pend_ff);
   assign load     = cmd_valid && cmd_free;
   assign col_ext  = {1'b0, cmd.col};

   always_comb begin
      out_valid_in = load || (out_valid_ff && (rsp_stall || pend_ff));
      out_font_in  = out_font_ff;
      out_ofs_in   = out_ofs_ff;
      out_col_in   = out_col_ff;
      out_last_in  = out_last_ff;
      pend_in      = pend_ff;
      pend_ofs_in  = pend_ofs_ff;
      pend_col_in  = pend_col_ff;
      if (load) begin
         out_font_in = cmd.font;
         out_ofs_in  = cmd.offset;
         out_col_in  = cmd.pair ? col_ext - sjgad_pkg::DRAW_BITS'(8) : col_ext;
         out_last_in = !cmd.pair;
         pend_in     = cmd.pair;
         pend_ofs_in = cmd.offset + sjgad_pkg::OFFSET_BITS'(sjgad_pkg::GLYPH_BYTES);
         pend_col_in = col_ext;
      end else if (beat && pend_ff) begin
         out_ofs_in  = pend_ofs_ff;
         out_col_in  = pend_col_ff;
         out_last_in = 1'b1;
         pend_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         pend_ff      <= pend_in;
      end
      out_font_ff <= out_font_in;
      out_ofs_ff  <= out_ofs_in;
      out_col_ff  <= out_col_in;
      out_last_ff <= out_last_in;
      pend_ofs_ff <= pend_ofs_in;
      pend_col_ff <= pend_col_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_font_select  = out_font_ff;
   assign rsp_glyph_offset = out_ofs_ff;
   assign rsp_draw_column  = out_col_ff;
   assign rsp_last_half    = out_last_ff;

endmodule
